// ===== rtl/asws_pkg.sv =====
// ----------------------------------------------------------------------------
// asws_pkg
// Shared types and constants for the array store with search: request and
// status codes, datapath command and status groups.
// ----------------------------------------------------------------------------
package asws_pkg;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned FIELD_W    = 7;   // position and count on the bus
  localparam int unsigned OUT_DATA_W = 48;  // 7 + 32 + 7 rounded up to bytes

  // Request kinds carried on the input tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND   = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_SEARCH   = 2'd2,
    REQ_TRAVERSE = 2'd3
  } req_type_e;

  // Result status carried on the output tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Datapath operations on the store
  typedef enum logic [2:0] {
    OP_NOP,
    OP_APPEND,
    OP_REMOVE,
    OP_START,
    OP_ADVANCE
  } dp_op_e;

  // Command group: controller to datapath
  typedef struct packed {
    dp_op_e  op;
    logic    out_load;
    status_e out_status;
    logic    out_pos;    // drive position from scan index
    logic    out_elem;   // drive element from read data
    logic    out_last;
  } dp_cmd_t;

  // Status group: datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic at_end;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/asws_ctrl.sv =====
// ----------------------------------------------------------------------------
// asws_ctrl
// Request controller: decodes accepted requests and sequences the entry scan
// for search and traverse.
// ----------------------------------------------------------------------------
module asws_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  asws_pkg::req_type_e        req_type_i,
  output logic                       req_ready_o,
  input  asws_pkg::dp_stat_t         stat_i,
  output asws_pkg::dp_cmd_t          cmd_o
);
  import asws_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TRAV
  } state_e;

  state_e state_q, state_d;

  // Accept only when the result register can take a result this cycle
  assign req_ready_o = (state_q == S_IDLE) && stat_i.out_free;

  // Next state and datapath command
  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.op           = OP_NOP;
    cmd_o.out_status   = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          cmd_o.out_last = 1'b1;
          unique case (req_type_i)
            REQ_APPEND: begin
              cmd_o.out_load = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_status = ST_FULL;
              end else begin
                cmd_o.op = OP_APPEND;
              end
            end
            REQ_REMOVE: begin
              cmd_o.out_load = 1'b1;
              if (stat_i.empty) begin
                cmd_o.out_status = ST_EMPTY;
              end else begin
                cmd_o.op = OP_REMOVE;
              end
            end
            REQ_SEARCH: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_NOTFOUND;
              end else begin
                cmd_o.op = OP_START;
                state_d  = S_SCAN;
              end
            end
            REQ_TRAVERSE: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
              end else begin
                cmd_o.op = OP_START;
                state_d  = S_TRAV;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // Compare one entry per cycle, stop on first hit or at the end
        cmd_o.out_last = 1'b1;
        if (stat_i.match) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_pos  = 1'b1;
          state_d        = S_IDLE;
        end else if (stat_i.at_end) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_NOTFOUND;
          state_d          = S_IDLE;
        end else begin
          cmd_o.op = OP_ADVANCE;
        end
      end
      S_TRAV: begin
        // Emit one entry whenever the result register frees up
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_pos  = 1'b1;
          cmd_o.out_elem = 1'b1;
          cmd_o.out_last = stat_i.at_end;
          if (stat_i.at_end) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.op = OP_ADVANCE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/asws_dp.sv =====
// ----------------------------------------------------------------------------
// asws_dp
// Store datapath: entry memory, fill count, scan index, search key and the
// result register.
// ----------------------------------------------------------------------------
module asws_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [asws_pkg::VALUE_W-1:0]        value_i,
  input  asws_pkg::dp_cmd_t                   cmd_i,
  output asws_pkg::dp_stat_t                  stat_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [asws_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic [asws_pkg::STATUS_W-1:0]       out_status_o,
  output logic                                out_last_o
);
  import asws_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_q;
  logic [VALUE_W-1:0] key_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      idx_inc;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  logic               out_valid_q;
  logic [FIELD_W-1:0] out_pos_q;
  logic [VALUE_W-1:0] out_elem_q;
  logic [FIELD_W-1:0] out_count_q;
  status_e            out_status_q;
  logic               out_last_q;

  logic [CW+FIELD_W-1:0] pos_ext;
  logic [CW+FIELD_W-1:0] count_ext;

  assign idx_inc = idx_q + ONE_C;

  // Status toward the controller
  assign stat_o.full     = (count_q == DEPTH_C);
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.match    = (rdata_q == key_q);
  assign stat_o.at_end   = (idx_inc == count_q);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Fill count and scan index
  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    unique case (cmd_i.op)
      OP_APPEND:  count_d = count_q + ONE_C;
      OP_REMOVE:  count_d = count_q - ONE_C;
      OP_START:   idx_d   = '0;
      OP_ADVANCE: idx_d   = idx_inc;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Latch the search key at scan start
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_START) begin
      key_q <= value_i;
    end
  end

  // Entry memory: one write port, one registered read port
  assign rd_en   = (cmd_i.op == OP_START) || (cmd_i.op == OP_ADVANCE);
  assign rd_addr = (cmd_i.op == OP_START) ? '0 : idx_inc[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_APPEND) begin
      mem[count_q[AW-1:0]] <= value_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Trim position and count to the bus field width
  assign pos_ext   = {{FIELD_W{1'b0}}, idx_inc};
  assign count_ext = {{FIELD_W{1'b0}}, count_d};

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_last_q   <= cmd_i.out_last;
      out_count_q  <= count_ext[FIELD_W-1:0];
      out_pos_q    <= cmd_i.out_pos ? pos_ext[FIELD_W-1:0] : '0;
      out_elem_q   <= cmd_i.out_elem ? rdata_q : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;
  assign out_data_o   = {{(OUT_DATA_W - 2*FIELD_W - VALUE_W){1'b0}},
                         out_count_q, out_elem_q, out_pos_q};

endmodule

// ===== rtl/array_store_with_search.sv =====
// ----------------------------------------------------------------------------
// array_store_with_search
// Bounded store of signed 32-bit entries with append, remove-last, linear
// search and in-order traverse.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tuser selects append, remove,
//   search or traverse and tdata carries the value. Results leave on the
//   m_axis channel, one per request, or one per stored entry on traverse,
//   with tlast on the final result of each request.
//   Append and remove give their result in the cycle after the transaction.
//   Search reads one entry per cycle from the entry memory's single read
//   port. A new request is taken as soon as the previous one has loaded its
//   final result and the result register is free or being emptied in the
//   same cycle.
//   Reset empties the store (fill count zero) and drops any pending result;
//   entry contents are not cleared. A receiver stall holds the result
//   register, pauses a traverse in place and holds off new requests.
// ----------------------------------------------------------------------------
module array_store_with_search #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [asws_pkg::VALUE_W-1:0]        s_axis_tdata,   // value
  input  logic [asws_pkg::REQ_W-1:0]          s_axis_tuser,   // req_type
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // position [6:0], element [38:7], count [45:39], zero fill [47:46]
  output logic [asws_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [asws_pkg::STATUS_W-1:0]       m_axis_tuser,   // status
  output logic                                m_axis_tlast    // last
);
  import asws_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  req_type_e req_type;

  assign req_type = req_type_e'(s_axis_tuser);

  // Request sequencing
  asws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_type_i  (req_type),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Store and result register
  asws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (s_axis_tdata),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule
